FILE: hdl/bef_pkg.sv
// Shared types and constants for the bond electric-field force unit.
package bef_pkg;

    localparam int DATA_W = 32;   // Q format word
    localparam int MAG_W  = 33;   // magnitude of a coordinate difference
    localparam int NORM_W = 31;   // normalized magnitude, top bit at position 30
    localparam int RAD_W  = 64;   // sum of squares
    localparam int ROOT_W = 32;   // bond length after normalization
    localparam int DE_W   = 34;   // projection u.E, signed
    localparam int T_W    = 35;   // t term, signed
    localparam int KD_W   = 64;   // |k| * |de|

    typedef enum logic [1:0] {
        REG_FORCE_CONSTANT = 2'd0,
        REG_FIELD_X        = 2'd1,
        REG_FIELD_Y        = 2'd2,
        REG_FIELD_Z        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] first_x;
        logic signed [DATA_W-1:0] first_y;
        logic signed [DATA_W-1:0] first_z;
        logic signed [DATA_W-1:0] second_x;
        logic signed [DATA_W-1:0] second_y;
        logic signed [DATA_W-1:0] second_z;
        logic                     in_group_first;
        logic                     in_group_second;
        logic                     last_bond;
    } bond_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic                     apply_first;
        logic                     apply_second;
        logic                     degenerate;
        logic                     last_out;
    } force_out_t;

    // flags that ride along the pipeline; degenerate is set in s2
    typedef struct packed {
        logic apply_first;
        logic apply_second;
        logic degenerate;
        logic last_out;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

endpackage

FILE: hdl/bef_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module bef_sqrt
    import bef_pkg::*;
#(
    parameter int TAG_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [RAD_W-1:0]  rad,
    input  logic [TAG_W-1:0]  tag_in,
    output logic              vld_out,
    output logic [ROOT_W-1:0] root,
    output logic [TAG_W-1:0]  tag_out
);

    localparam int STEPS = ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    logic [REM_W-1:0]  rem_reg  [1:STEPS];
    logic [ROOT_W-1:0] root_reg [1:STEPS];
    logic [RAD_W-1:0]  rad_reg  [1:STEPS];
    logic [TAG_W-1:0]  tag_reg  [1:STEPS];
    logic              vld_reg  [1:STEPS];

    logic [REM_W-1:0]  rem_cur  [0:STEPS-1];
    logic [ROOT_W-1:0] root_cur [0:STEPS-1];
    logic [RAD_W-1:0]  rad_cur  [0:STEPS-1];
    logic [TAG_W-1:0]  tag_cur  [0:STEPS-1];
    logic              vld_cur  [0:STEPS-1];

    assign rem_cur[0]  = '0;
    assign root_cur[0] = '0;
    assign rad_cur[0]  = rad;
    assign tag_cur[0]  = tag_in;
    assign vld_cur[0]  = vld_in;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [REM_W+1:0]  rem_s;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W+1:0]  rem_d;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k > 0) begin : g_link
            assign rem_cur[k]  = rem_reg[k];
            assign root_cur[k] = root_reg[k];
            assign rad_cur[k]  = rad_reg[k];
            assign tag_cur[k]  = tag_reg[k];
            assign vld_cur[k]  = vld_reg[k];
        end

        always_comb
        begin
            rem_s     = {rem_cur[k], rad_cur[k][RAD_W-1 -: 2]};
            trial     = {1'b0, root_cur[k], 2'b01};
            ge        = (rem_s >= trial);
            rem_d     = ge ? (rem_s - trial) : rem_s;
            rem_next  = rem_d[REM_W-1:0];
            root_next = {root_cur[k][ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_cur[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                rad_reg[k+1]  <= {rad_cur[k][RAD_W-3:0], 2'b00};
                tag_reg[k+1]  <= tag_cur[k];
            end
        end
    end

    assign vld_out = vld_reg[STEPS];
    assign root    = root_reg[STEPS];
    assign tag_out = tag_reg[STEPS];

endmodule

FILE: hdl/bef_div.sv
// Three-lane pipelined restoring divider with a shared divisor, rounded quotient.
module bef_div
    import bef_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int TAG_W     = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       vld_in,
    input  logic [2:0][NORM_W-1:0]     num,
    input  logic [ROOT_W-1:0]          den,
    input  logic [TAG_W-1:0]           tag_in,
    output logic                       vld_out,
    output logic [2:0][FRAC_BITS:0]    quo,
    output logic [TAG_W-1:0]           tag_out
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int NW    = NORM_W + FRAC_BITS + 1;

    logic [2:0][ROOT_W-1:0] rem_reg [1:STEPS];
    logic [2:0][STEPS-1:0]  low_reg [1:STEPS];
    logic [2:0][STEPS-1:0]  q_reg   [1:STEPS];
    logic [ROOT_W-1:0]      den_reg [1:STEPS];
    logic [TAG_W-1:0]       tag_reg [1:STEPS];
    logic                   vld_reg [1:STEPS];

    logic [2:0][ROOT_W-1:0] rem_cur [0:STEPS-1];
    logic [2:0][STEPS-1:0]  low_cur [0:STEPS-1];
    logic [2:0][STEPS-1:0]  q_cur   [0:STEPS-1];
    logic [ROOT_W-1:0]      den_cur [0:STEPS-1];
    logic [TAG_W-1:0]       tag_cur [0:STEPS-1];
    logic                   vld_cur [0:STEPS-1];

    // dividend n * 2^F + floor(L/2); quotient fits in F+1 bits
    logic [2:0][NW-1:0] dvd;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dvd[i] = {1'b0, num[i], {FRAC_BITS{1'b0}}} + NW'(den >> 1);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_init
        assign rem_cur[0][i] = ROOT_W'(dvd[i][NW-1:STEPS]);
        assign low_cur[0][i] = dvd[i][STEPS-1:0];
    end
    assign q_cur[0]   = '0;
    assign den_cur[0] = den;
    assign tag_cur[0] = tag_in;
    assign vld_cur[0] = vld_in;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [2:0][ROOT_W-1:0] rem_next;
        logic [2:0][STEPS-1:0]  q_next;
        logic [ROOT_W:0]        rem_s;
        logic                   ge;

        if (k > 0) begin : g_link
            assign rem_cur[k] = rem_reg[k];
            assign low_cur[k] = low_reg[k];
            assign q_cur[k]   = q_reg[k];
            assign den_cur[k] = den_reg[k];
            assign tag_cur[k] = tag_reg[k];
            assign vld_cur[k] = vld_reg[k];
        end

        always_comb
        begin
            rem_s = '0;
            ge    = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                rem_s       = {rem_cur[k][i], low_cur[k][i][STEPS-1]};
                ge          = (rem_s >= {1'b0, den_cur[k]});
                rem_next[i] = ge ? ROOT_W'(rem_s - {1'b0, den_cur[k]})
                                 : ROOT_W'(rem_s);
                q_next[i]   = {q_cur[k][i][STEPS-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_cur[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                q_reg[k+1]   <= q_next;
                for (int i = 0; i < 3; i++)
                begin
                    low_reg[k+1][i] <= {low_cur[k][i][STEPS-2:0], 1'b0};
                end
                den_reg[k+1] <= den_cur[k];
                tag_reg[k+1] <= tag_cur[k];
            end
        end
    end

    assign vld_out = vld_reg[STEPS];
    assign quo     = q_reg[STEPS];
    assign tag_out = tag_reg[STEPS];

endmodule

FILE: hdl/bond_electric_field_force_unit.sv
// Bond electric-field force unit: top level, front end, back end and config registers.
// Stages from input accept to result accept: 5 front stages, 32 square-root stages,
//   FRAC_BITS+1 divider stages, 6 back stages.
// Throughput: one item per cycle while the output is not stalled; every stage is a
//   register stage of one shared pipeline. A stalled output freezes the whole pipeline;
//   in_stall is high only while the output register holds a result that is stalled.
// Reset clears all valid bits and the four config registers; no clearing pass.
module bond_electric_field_force_unit
    import bef_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bond_in_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output force_out_t        out_item,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    localparam int UW   = FRAC_BITS + 2;
    localparam int PW   = UW + DATA_W;
    localparam int SW   = UW + DATA_W + 2;
    localparam int DUW  = DE_W + UW;
    localparam int TM_W = T_W - 1;
    localparam int PP_W = DATA_W + TM_W;
    localparam int QW   = PP_W + DATA_W + 1;
    localparam int SQ_W = 2 * NORM_W;
    localparam int POS_W = $clog2(MAG_W + 1);
    localparam int SQRT_TAG_W = 3 * NORM_W + 3 + SIDE_W;
    localparam int DIV_TAG_W  = 3 + SIDE_W;

    // ---------------- config registers
    logic [DATA_W-1:0]      k_reg;
    logic [2:0][DATA_W-1:0] e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            e_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FORCE_CONSTANT: k_reg    <= cfg_data;
                REG_FIELD_X:        e_reg[0] <= cfg_data;
                REG_FIELD_Y:        e_reg[1] <= cfg_data;
                REG_FIELD_Z:        e_reg[2] <= cfg_data;
                default:            k_reg    <= k_reg;
            endcase
        end
    end

    // ---------------- global pipeline enable
    logic en;
    logic b6_vld_reg;

    assign en        = !(b6_vld_reg && out_stall);
    assign in_stall  = !en;
    assign out_valid = b6_vld_reg;

    // ---------------- s1: differences, sign and magnitude
    logic [2:0][DATA_W-1:0] pa;
    logic [2:0][DATA_W-1:0] pb;
    logic [2:0][MAG_W-1:0]  s1_mag_next;
    logic [2:0]             s1_neg_next;
    logic [MAG_W-1:0]       dif;

    logic                   s1_vld_reg;
    logic [2:0][MAG_W-1:0]  s1_mag_reg;
    logic [2:0]             s1_neg_reg;
    side_t                  s1_side_reg;

    assign pa = {in_item.first_z, in_item.first_y, in_item.first_x};
    assign pb = {in_item.second_z, in_item.second_y, in_item.second_x};

    always_comb
    begin
        dif = '0;
        for (int i = 0; i < 3; i++)
        begin
            dif            = {pb[i][DATA_W-1], pb[i]} - {pa[i][DATA_W-1], pa[i]};
            s1_neg_next[i] = dif[MAG_W-1];
            s1_mag_next[i] = dif[MAG_W-1] ? (~dif + 1'b1) : dif;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= s1_mag_next;
            s1_neg_reg  <= s1_neg_next;
            s1_side_reg <= '{apply_first:  in_item.in_group_first,
                              apply_second: in_item.in_group_second,
                              degenerate:   1'b0,
                              last_out:     in_item.last_bond};
        end
    end

    // ---------------- s2: leading-one position of the largest magnitude
    logic [MAG_W-1:0]       or_mag;
    logic [POS_W-1:0]       s2_pos_next;
    side_t                  s2_side_next;

    logic                   s2_vld_reg;
    logic [2:0][MAG_W-1:0]  s2_mag_reg;
    logic [2:0]             s2_neg_reg;
    logic [POS_W-1:0]       s2_pos_reg;
    side_t                  s2_side_reg;

    always_comb
    begin
        // the top bit of the OR is the top bit of the maximum
        or_mag      = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];
        s2_pos_next = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (or_mag[b])
            begin
                s2_pos_next = POS_W'(b);
            end
        end
        s2_side_next            = s1_side_reg;
        s2_side_next.degenerate = (or_mag == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_pos_reg  <= s2_pos_next;
            s2_side_reg <= s2_side_next;
        end
    end

    // ---------------- s3: normalize so the largest lies in [2^30, 2^31)
    localparam logic [POS_W-1:0] TOP_POS = POS_W'(NORM_W - 1);

    logic [2:0][NORM_W-1:0] s3_n_next;
    logic [MAG_W-1:0]       shv;

    logic                   s3_vld_reg;
    logic [2:0][NORM_W-1:0] s3_n_reg;
    logic [2:0]             s3_neg_reg;
    side_t                  s3_side_reg;

    always_comb
    begin
        shv = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (s2_pos_reg > TOP_POS)
            begin
                shv = s2_mag_reg[i] >> (s2_pos_reg - TOP_POS);
            end
            else
            begin
                shv = s2_mag_reg[i] << (TOP_POS - s2_pos_reg);
            end
            s3_n_next[i] = shv[NORM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_n_reg    <= s3_n_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // ---------------- s4: squares
    logic                   s4_vld_reg;
    logic [2:0][SQ_W-1:0]   s4_sq_reg;
    logic [2:0][NORM_W-1:0] s4_n_reg;
    logic [2:0]             s4_neg_reg;
    side_t                  s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_sq_reg[i] <= SQ_W'(s3_n_reg[i]) * SQ_W'(s3_n_reg[i]);
            end
            s4_n_reg    <= s3_n_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // ---------------- s5: sum of squares
    logic                   s5_vld_reg;
    logic [RAD_W-1:0]       s5_rad_reg;
    logic [2:0][NORM_W-1:0] s5_n_reg;
    logic [2:0]             s5_neg_reg;
    side_t                  s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_rad_reg  <= RAD_W'(s4_sq_reg[0]) + RAD_W'(s4_sq_reg[1])
                           + RAD_W'(s4_sq_reg[2]);
            s5_n_reg    <= s4_n_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    // ---------------- length
    logic                   sq_vld;
    logic [ROOT_W-1:0]      sq_root;
    logic [SQRT_TAG_W-1:0]  sq_tag;
    logic [2:0][NORM_W-1:0] sq_n;
    logic [2:0]             sq_neg;
    side_t                  sq_side;

    bef_sqrt #(
        .TAG_W (SQRT_TAG_W)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (s5_vld_reg),
        .rad     (s5_rad_reg),
        .tag_in  ({s5_n_reg, s5_neg_reg, s5_side_reg}),
        .vld_out (sq_vld),
        .root    (sq_root),
        .tag_out (sq_tag)
    );

    assign {sq_n, sq_neg, sq_side} = sq_tag;

    // ---------------- unit vector
    logic                  dv_vld;
    logic [2:0][FRAC_BITS:0] dv_q;
    logic [DIV_TAG_W-1:0]  dv_tag;
    logic [2:0]            dv_neg;
    side_t                 dv_side;

    bef_div #(
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (DIV_TAG_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (sq_vld),
        .num     (sq_n),
        .den     (sq_root),
        .tag_in  ({sq_neg, sq_side}),
        .vld_out (dv_vld),
        .quo     (dv_q),
        .tag_out (dv_tag)
    );

    assign {dv_neg, dv_side} = dv_tag;

    // ---------------- b1: signed u and u_i * E_i
    logic signed [2:0][UW-1:0] b1_u_next;

    logic                      b1_vld_reg;
    logic signed [2:0][UW-1:0] b1_u_reg;
    logic signed [2:0][PW-1:0] b1_prod_reg;
    side_t                     b1_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b1_u_next[i] = dv_neg[i] ? -$signed(UW'(dv_q[i])) : $signed(UW'(dv_q[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b1_prod_reg[i] <= PW'($signed(b1_u_next[i]) * $signed(e_reg[i]));
            end
            b1_u_reg    <= b1_u_next;
            b1_side_reg <= dv_side;
        end
    end

    // ---------------- b2: de = round(u.E)
    logic signed [SW-1:0] dot_sum;
    logic [SW-1:0]        dot_mag;
    logic [SW-1:0]        dot_rnd;
    logic signed [DE_W-1:0] b2_de_next;

    logic                      b2_vld_reg;
    logic signed [DE_W-1:0]    b2_de_reg;
    logic signed [2:0][UW-1:0] b2_u_reg;
    side_t                     b2_side_reg;

    always_comb
    begin
        dot_sum = SW'($signed(b1_prod_reg[0])) + SW'($signed(b1_prod_reg[1]))
                  + SW'($signed(b1_prod_reg[2]));
        dot_mag = dot_sum[SW-1] ? (~dot_sum + 1'b1) : dot_sum;
        dot_rnd = (dot_mag + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        b2_de_next = dot_sum[SW-1] ? -$signed(DE_W'(dot_rnd)) : $signed(DE_W'(dot_rnd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b2_vld_reg <= b1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_de_reg   <= b2_de_next;
            b2_u_reg    <= b1_u_reg;
            b2_side_reg <= b1_side_reg;
        end
    end

    // ---------------- b3: de * u_i and |k| * |de|
    logic [DATA_W-1:0] k_mag;
    logic [DE_W-2:0]   de_mag;
    logic [DE_W-1:0]   de_neg_w;

    logic                       b3_vld_reg;
    logic signed [2:0][DUW-1:0] b3_du_reg;
    logic [KD_W-1:0]            b3_kd_reg;
    logic                       b3_kneg_reg;
    side_t                      b3_side_reg;

    always_comb
    begin
        k_mag    = k_reg[DATA_W-1] ? (~k_reg + 1'b1) : k_reg;
        de_neg_w = ~b2_de_reg + 1'b1;
        de_mag   = b2_de_reg[DE_W-1] ? de_neg_w[DE_W-2:0] : b2_de_reg[DE_W-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b3_vld_reg <= b2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b3_du_reg[i] <= DUW'(b2_de_reg * $signed(b2_u_reg[i]));
            end
            b3_kd_reg   <= KD_W'(k_mag) * KD_W'(de_mag);
            b3_kneg_reg <= k_reg[DATA_W-1] ^ b2_de_reg[DE_W-1];
            b3_side_reg <= b2_side_reg;
        end
    end

    // ---------------- b4: t_i = round(de*u_i) - 2*E_i
    logic [2:0][TM_W-1:0] b4_tm_next;
    logic [2:0]           b4_neg_next;
    logic [DUW-1:0]       du_mag;
    logic [DUW-1:0]       du_rnd;
    logic signed [T_W-1:0] du_s;
    logic signed [T_W-1:0] t_val;
    logic [T_W-1:0]        t_neg_w;

    logic                 b4_vld_reg;
    logic [2:0][TM_W-1:0] b4_tm_reg;
    logic [2:0]           b4_neg_reg;
    logic [KD_W-1:0]      b4_kd_reg;
    side_t                b4_side_reg;

    always_comb
    begin
        du_mag  = '0;
        du_rnd  = '0;
        du_s    = '0;
        t_val   = '0;
        t_neg_w = '0;
        for (int i = 0; i < 3; i++)
        begin
            du_mag = b3_du_reg[i][DUW-1] ? (~b3_du_reg[i] + 1'b1) : b3_du_reg[i];
            du_rnd = (du_mag + (DUW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            du_s   = b3_du_reg[i][DUW-1] ? -$signed(T_W'(du_rnd)) : $signed(T_W'(du_rnd));
            t_val  = du_s - $signed({e_reg[i][DATA_W-1], e_reg[i][DATA_W-1], e_reg[i], 1'b0});
            t_neg_w = ~t_val + 1'b1;
            b4_tm_next[i]  = t_val[T_W-1] ? t_neg_w[TM_W-1:0] : t_val[TM_W-1:0];
            b4_neg_next[i] = b3_kneg_reg ^ t_val[T_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b4_vld_reg <= b3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b4_tm_reg   <= b4_tm_next;
            b4_neg_reg  <= b4_neg_next;
            b4_kd_reg   <= b3_kd_reg;
            b4_side_reg <= b3_side_reg;
        end
    end

    // ---------------- b5: partial products of |k*de| * |t_i|
    logic                 b5_vld_reg;
    logic [2:0][PP_W-1:0] b5_lo_reg;
    logic [2:0][PP_W-1:0] b5_hi_reg;
    logic [2:0]           b5_neg_reg;
    side_t                b5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b5_vld_reg <= b4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b5_lo_reg[i] <= PP_W'(b4_kd_reg[DATA_W-1:0]) * PP_W'(b4_tm_reg[i]);
                b5_hi_reg[i] <= PP_W'(b4_kd_reg[KD_W-1:DATA_W]) * PP_W'(b4_tm_reg[i]);
            end
            b5_neg_reg  <= b4_neg_reg;
            b5_side_reg <= b4_side_reg;
        end
    end

    // ---------------- b6: combine, round, saturate, zero degenerate bonds
    localparam logic [QW-1:0] SAT_POS = QW'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic [QW-1:0] SAT_NEG = QW'(1) << (DATA_W - 1);

    logic [2:0][DATA_W-1:0] f_next;
    logic [QW-1:0]          q_sum;
    logic [QW-1:0]          q_rnd;
    logic [QW-1:0]          q_lim;
    logic [DATA_W-1:0]      q_mag;

    force_out_t             out_item_reg;

    always_comb
    begin
        q_sum = '0;
        q_rnd = '0;
        q_lim = '0;
        q_mag = '0;
        for (int i = 0; i < 3; i++)
        begin
            q_sum = (QW'(b5_hi_reg[i]) << DATA_W) + QW'(b5_lo_reg[i])
                    + (QW'(1) << (2 * FRAC_BITS - 1));
            q_rnd = q_sum >> (2 * FRAC_BITS);
            q_lim = b5_neg_reg[i] ? SAT_NEG : SAT_POS;
            q_mag = (q_rnd > q_lim) ? q_lim[DATA_W-1:0] : q_rnd[DATA_W-1:0];
            if (b5_side_reg.degenerate)
            begin
                f_next[i] = '0;
            end
            else
            begin
                f_next[i] = b5_neg_reg[i] ? (~q_mag + 1'b1) : q_mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b6_vld_reg <= b5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item_reg.force_x      <= f_next[0];
            out_item_reg.force_y      <= f_next[1];
            out_item_reg.force_z      <= f_next[2];
            out_item_reg.apply_first  <= b5_side_reg.apply_first;
            out_item_reg.apply_second <= b5_side_reg.apply_second;
            out_item_reg.degenerate   <= b5_side_reg.degenerate;
            out_item_reg.last_out     <= b5_side_reg.last_out;
        end
    end

    assign out_item = out_item_reg;

`ifndef ASSERT_OFF
    // a zero-length bond must come out with zero force
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.degenerate |->
            out_item.force_x == '0 && out_item.force_y == '0 && out_item.force_z == '0)
        else $error("degenerate bond with nonzero force");

    // normalized length always has one of its two top bits set
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld && !sq_side.degenerate |-> sq_root[ROOT_W-1:ROOT_W-2] != 2'b00)
        else $error("bond length out of normalized range");

    // unit vector components never exceed one
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld && !dv_side.degenerate |->
            dv_q[0] <= (FRAC_BITS+1)'(1) << FRAC_BITS &&
            dv_q[1] <= (FRAC_BITS+1)'(1) << FRAC_BITS &&
            dv_q[2] <= (FRAC_BITS+1)'(1) << FRAC_BITS)
        else $error("unit vector component above one");

    // a stalled pipeline holds its last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> b6_vld_reg && $stable(out_item_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

FILE: sim/tb_bond_electric_field_force_unit.sv
// Self-checking testbench for the bond electric-field force unit.
module tb_bond_electric_field_force_unit;
    import bef_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int LATENCY    = FRAC + 43;
    localparam int IDLE_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    bond_in_t   in_item;
    logic       out_valid;
    logic       out_stall;
    force_out_t out_item;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    bond_electric_field_force_unit #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    longint     coupling_k;
    longint     field_q[3];
    force_out_t force_q[$];
    int         fail_count;
    int         send_pct;
    int         stall_pct;
    int         quiet_cycles;

    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic force_out_t predict_force(bond_in_t b);
        longint       d[3];
        logic [63:0]  nm[3];
        bit           neg[3];
        logic [63:0]  m;
        logic [63:0]  sq;
        logic [63:0]  len;
        logic [63:0]  q;
        longint       u[3];
        longint       acc;
        longint       de;
        longint       t;
        logic [63:0]  kd;
        logic [63:0]  mt;
        logic [63:0]  lim;
        logic [127:0] p;
        logic [31:0]  f[3];
        bit           n;
        force_out_t   r;
        d[0] = longint'(b.second_x) - longint'(b.first_x);
        d[1] = longint'(b.second_y) - longint'(b.first_y);
        d[2] = longint'(b.second_z) - longint'(b.first_z);
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = d[i] < 0;
            nm[i]  = neg[i] ? -d[i] : d[i];
            if (nm[i] > m)
                m = nm[i];
        end
        r.apply_first  = b.in_group_first;
        r.apply_second = b.in_group_second;
        r.last_out     = b.last_bond;
        r.degenerate   = (m == 0);
        f = '{0, 0, 0};
        if (m != 0)
        begin
            while (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                for (int i = 0; i < 3; i++)
                    nm[i] = nm[i] >> 1;
            end
            while (m < (64'd1 << 30))
            begin
                m = m << 1;
                for (int i = 0; i < 3; i++)
                    nm[i] = nm[i] << 1;
            end
            sq = nm[0] * nm[0] + nm[1] * nm[1] + nm[2] * nm[2];
            len = int_sqrt(sq);
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                q    = ((nm[i] << FRAC) + (len >> 1)) / len;
                u[i] = neg[i] ? -longint'(q) : longint'(q);
                acc  = acc + u[i] * field_q[i];
            end
            de = round_shift(acc, FRAC);
            for (int i = 0; i < 3; i++)
            begin
                t   = round_shift(de * u[i], FRAC) - 2 * field_q[i];
                n   = ((coupling_k < 0) != (de < 0)) != (t < 0);
                kd  = ((coupling_k < 0) ? -coupling_k : coupling_k) * ((de < 0) ? -de : de);
                mt  = (t < 0) ? -t : t;
                p   = ({64'd0, kd} * {64'd0, mt} + (128'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
                lim = n ? 64'h8000_0000 : 64'h7FFF_FFFF;
                if (p > {64'd0, lim})
                    p = {64'd0, lim};
                f[i] = n ? -p[31:0] : p[31:0];
            end
        end
        r.force_x = f[0];
        r.force_y = f[1];
        r.force_z = f[2];
        return r;
    endfunction

    // register writes only once the pipeline has drained
    task automatic write_field(longint k, longint ex, longint ey, longint ez);
        logic [31:0] vals[4];
        wait (force_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        vals = '{k[31:0], ex[31:0], ey[31:0], ez[31:0]};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        coupling_k = longint'(signed'(vals[REG_FORCE_CONSTANT]));
        field_q[0] = longint'(signed'(vals[REG_FIELD_X]));
        field_q[1] = longint'(signed'(vals[REG_FIELD_Y]));
        field_q[2] = longint'(signed'(vals[REG_FIELD_Z]));
    endtask

    task automatic send_bond(bond_in_t b, bit typed, force_out_t want);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= b;
        do
            @(posedge clk);
        while (in_stall);
        force_q.push_back(typed ? want : predict_force(b));
    endtask

    function automatic bond_in_t random_bond();
        bond_in_t b;
        logic [31:0] dx;
        b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 3'($urandom)};
        case ($urandom_range(5))
            0, 1:
            begin
                // short bond with a few fraction bits of length
                dx = $urandom_range(1 << 20);
                b.second_x = b.first_x + (($urandom_range(1)) ? dx : -dx);
                b.second_y = b.first_y + 32'($signed($urandom_range(1 << 18)) - (1 << 17));
                b.second_z = b.first_z + 32'($signed($urandom_range(1 << 18)) - (1 << 17));
            end
            2:
            begin
                b.second_x = b.first_x;
                b.second_y = b.first_y;
                b.second_z = b.first_z;
            end
            3:
            begin
                b.second_y = b.first_y;
                b.second_z = b.first_z;
            end
            default: ;
        endcase
        return b;
    endfunction

    typedef struct {
        bond_in_t   b;
        bit         typed;
        force_out_t want;
    } row_t;

    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    row_t rows[] = '{
        '{'{0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1}, 1, '{0, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1}},
        '{'{MAXV, MINV, 5, MAXV, MINV, 5, 1'b0, 1'b1, 1'b0}, 1,
          '{0, 0, 0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{MINV, MINV, MINV, MAXV, MAXV, MAXV, 1'b1, 1'b0, 1'b0}, 1,
          '{0, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{MAXV, MAXV, MAXV, MINV, MINV, MINV, 1'b0, 1'b0, 1'b1}, 1,
          '{0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{0, 0, 0, 1, 0, 0, 1'b1, 1'b1, 1'b0}, 0, '0},
        '{'{0, 0, 0, 0, ONE, 0, 1'b1, 1'b1, 1'b0}, 0, '0},
        '{'{0, 0, 0, 0, 0, MINV, 1'b1, 1'b1, 1'b0}, 0, '0},
        '{'{MINV, 0, 0, MAXV, 0, 0, 1'b0, 1'b1, 1'b0}, 0, '0},
        '{'{MAXV, 0, MAXV, MINV, 1, MINV, 1'b1, 1'b0, 1'b1}, 0, '0},
        '{'{ONE, ONE, ONE, 0, 0, 0, 1'b1, 1'b1, 1'b1}, 0, '0},
        '{'{0, 0, 0, 3, 4, 12, 1'b0, 1'b0, 1'b0}, 0, '0},
        '{'{MINV, MINV, MINV, MINV, MINV, MINV, 1'b1, 1'b1, 1'b1}, 0, '0}
    };

    always @(posedge clk)
    begin
        force_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (force_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_item);
                fail_count++;
            end
            else
            begin
                want = force_q.pop_front();
                if (out_item !== want)
                begin
                    $display("%0t: force mismatch expected %h actual %h", $time, want, out_item);
                    fail_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int pct[4][2] = '{'{0, 0}, '{77, 0}, '{0, 77}, '{11, 11}};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FORCE_CONSTANT;
        cfg_data     = '0;
        coupling_k   = 0;
        field_q      = '{0, 0, 0};
        fail_count   = 0;
        quiet_cycles = 0;
        send_pct     = 0;
        stall_pct    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // with k and E at reset every force is zero, so only the flags matter
        foreach (rows[r])
            send_bond(rows[r].b, rows[r].typed, rows[r].want);
        in_valid <= 1'b0;

        write_field(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF);
        foreach (rows[r])
            send_bond(rows[r].b, 0, '0);
        in_valid <= 1'b0;

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_field(-2147483648, -2147483648, -2147483648, -2147483648);
                1: write_field(1 << 16, 2 << 16, -(1 << 15), 3 << 16);
                2: write_field(2147483647, 1, -1, 0);
                3: write_field(-(5 << 16), 0, 0, 1 << 16);
                default: write_field(longint'(signed'($urandom)) >>> $urandom_range(20),
                                     longint'(signed'($urandom)) >>> $urandom_range(20),
                                     longint'(signed'($urandom)) >>> $urandom_range(20),
                                     longint'(signed'($urandom)) >>> $urandom_range(20));
            endcase
            send_pct  = pct[ph % 4][0];
            stall_pct = pct[ph % 4][1];
            for (int n = 0; n < 125; n++)
            begin
                if (ph == 5 && n == 60)
                begin
                    in_valid <= 1'b0;
                    wait (force_q.size() == 0);
                    @(posedge clk);
                end
                send_bond(random_bond(), 0, '0);
            end
            in_valid <= 1'b0;
        end
        stall_pct = 0;

        wait (force_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
